// ----- src/kdas_pkg.sv -----
`timescale 1ns / 1ps
`default_nettype none

package kdas_pkg;

    // Button count and derived widths
    localparam int NumButtons = 8;
    localparam int IdxW       = (NumButtons > 1) ? $clog2(NumButtons) : 1;
    localparam int LevelW     = 8;
    localparam int LimW       = 14;
    localparam int CntW       = 15;
    localparam int KindW      = 2;
    localparam int BtnW       = 3;
    localparam int CfgIdxW    = 2;

    // Register reset values
    localparam logic [LimW-1:0] DebounceReset  = LimW'(5);
    localparam logic [LimW-1:0] LongPressReset = LimW'(100);
    localparam logic [LimW-1:0] RptReset       = LimW'(20);

    // Register indexes
    localparam logic [CfgIdxW-1:0] CFG_DEBOUNCE   = 2'd0;
    localparam logic [CfgIdxW-1:0] CFG_LONG_PRESS = 2'd1;
    localparam logic [CfgIdxW-1:0] CFG_RPT        = 2'd2;

    typedef enum logic [1:0] {
        MODE_OFF  = 2'd0,
        MODE_ON   = 2'd1,
        MODE_HELD = 2'd2
    } t_mode;

    typedef enum logic [KindW-1:0] {
        KIND_ON     = 2'd0,
        KIND_REPEAT = 2'd1,
        KIND_TWO    = 2'd2
    } t_kind;

    typedef enum logic [1:0] {
        EV_NONE   = 2'd0,
        EV_ON     = 2'd1,
        EV_REPEAT = 2'd2
    } t_evt;

    // One memory word: the whole state of one button
    typedef struct packed {
        t_mode            mode;
        logic [CntW-1:0]  dc;
        logic [CntW-1:0]  pc;
    } t_btn_state;

    typedef struct packed {
        logic [LimW-1:0] debounce;
        logic [LimW-1:0] long_press;
        logic [LimW-1:0] rpt_interval;
    } t_limits;

endpackage

`default_nettype wire

// ----- src/kdas_state_mem.sv -----
`timescale 1ns / 1ps
`default_nettype none

module kdas_state_mem (
    input  wire logic                           i_clk,
    input  wire logic                           i_rst_n,
    input  wire logic                           i_rd_en,
    input  wire logic [kdas_pkg::IdxW-1:0]      i_rd_addr,
    output kdas_pkg::t_btn_state                o_rd_data,
    input  wire logic                           i_wr_en,
    input  wire logic [kdas_pkg::IdxW-1:0]      i_wr_addr,
    input  wire kdas_pkg::t_btn_state           i_wr_data
);

    kdas_pkg::t_btn_state                   mem [kdas_pkg::NumButtons];
    logic [kdas_pkg::NumButtons-1:0]        r_written;
    kdas_pkg::t_btn_state                   r_rd_data;
    logic                                   r_rd_hit;

    // Store the word; an entry never written reads as the reset state
    always_ff @(posedge i_clk) begin
        if (i_wr_en) begin
            mem[i_wr_addr] <= i_wr_data;
        end
        if (i_rd_en) begin
            r_rd_data <= mem[i_rd_addr];
        end
    end

    // Track written entries and register the hit with the read data
    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_written <= '0;
            r_rd_hit  <= 1'b0;
        end else begin
            if (i_wr_en) begin
                r_written[i_wr_addr] <= 1'b1;
            end
            if (i_rd_en) begin
                r_rd_hit <= r_written[i_rd_addr];
            end
        end
    end

    assign o_rd_data = r_rd_hit ? r_rd_data : '0;

endmodule

`default_nettype wire

// ----- src/kdas_btn_update.sv -----
`timescale 1ns / 1ps
`default_nettype none

module kdas_btn_update (
    input  wire kdas_pkg::t_btn_state   i_cur,
    input  wire logic                   i_pressed,
    input  wire kdas_pkg::t_limits      i_limits,
    output kdas_pkg::t_btn_state        o_next,
    output kdas_pkg::t_evt              o_evt
);

    logic [kdas_pkg::CntW-1:0] w_dc_inc;
    logic [kdas_pkg::CntW-1:0] w_pc_inc;
    logic [kdas_pkg::CntW-1:0] w_debounce;
    logic [kdas_pkg::CntW-1:0] w_long_press;
    logic [kdas_pkg::CntW-1:0] w_rpt_interval;

    assign w_dc_inc       = i_cur.dc + 1'b1;
    assign w_pc_inc       = i_cur.pc + 1'b1;
    assign w_debounce     = {1'b0, i_limits.debounce};
    assign w_long_press   = {1'b0, i_limits.long_press};
    assign w_rpt_interval = {1'b0, i_limits.rpt_interval};

    // Advance the debounce and press counters, move between modes
    always_comb begin
        o_next = i_cur;
        o_evt  = kdas_pkg::EV_NONE;
        case (i_cur.mode)
            kdas_pkg::MODE_OFF: begin
                if (i_pressed) begin
                    o_next.dc = w_dc_inc;
                    if (w_dc_inc > w_debounce) begin
                        o_next.mode = kdas_pkg::MODE_ON;
                        o_next.dc   = '0;
                        o_next.pc   = '0;
                        o_evt       = kdas_pkg::EV_ON;
                    end
                end else begin
                    o_next.dc = '0;
                end
            end
            kdas_pkg::MODE_ON, kdas_pkg::MODE_HELD: begin
                if (!i_pressed) begin
                    o_next.dc = w_dc_inc;
                    if (w_dc_inc > w_debounce) begin
                        o_next.mode = kdas_pkg::MODE_OFF;
                        o_next.dc   = '0;
                    end
                end else begin
                    o_next.dc = '0;
                    o_next.pc = w_pc_inc;
                    if (i_cur.mode == kdas_pkg::MODE_ON) begin
                        if (w_pc_inc > w_long_press) begin
                            o_next.mode = kdas_pkg::MODE_HELD;
                            o_next.pc   = '0;
                        end
                    end else if (w_pc_inc > w_rpt_interval) begin
                        o_next.pc = '0;
                        o_evt     = kdas_pkg::EV_REPEAT;
                    end
                end
            end
            default: begin
                o_next = i_cur;
            end
        endcase
    end

endmodule

`default_nettype wire

// ----- src/keypad_debounce_autorepeat_scanner.sv -----
`timescale 1ns / 1ps
`default_nettype none

// Keypad scanner with debounce, long press and auto-repeat. Each input item is
// one tick of raw active-low button levels and gives exactly one result item,
// which carries an event or all zeros. The per-button state sits in a small
// state memory with one read and one write port; a sequencer visits one button
// per cycle, reading the next button while writing back the current one, and
// stops at the first button that gives an event, so a tick visits 1 to 8
// buttons. The block takes no new tick while a scan runs and is ready for the
// next one once the result is loaded. A stalled output holds the scan at its
// last button. The state memory needs no clearing pass after reset.
// Configuration writes are always ready and belong to idle periods.
module keypad_debounce_autorepeat_scanner (
    input  wire logic                               i_clk,
    input  wire logic                               i_rst_n,
    // input channel
    input  wire logic                               i_in_valid,
    output      logic                               o_in_stall,
    input  wire logic [kdas_pkg::LevelW-1:0]        i_raw_levels,
    // output channel
    output      logic                               o_out_valid,
    input  wire logic                               i_out_stall,
    output      logic                               o_event_valid,
    output      logic [kdas_pkg::KindW-1:0]         o_event_kind,
    output      logic [kdas_pkg::BtnW-1:0]          o_button_index,
    output      logic [kdas_pkg::BtnW-1:0]          o_other_button,
    // configuration channel
    input  wire logic                               i_cfg_valid,
    output      logic                               o_cfg_ready,
    input  wire logic [kdas_pkg::CfgIdxW-1:0]       i_cfg_index,
    input  wire logic [kdas_pkg::LimW-1:0]          i_cfg_data
);

    localparam logic [kdas_pkg::IdxW-1:0] IdxLast = kdas_pkg::IdxW'(kdas_pkg::NumButtons - 1);

    typedef enum logic {
        ST_IDLE,
        ST_SCAN
    } t_state;

    t_state                                 r_state, n_state;
    logic [kdas_pkg::IdxW-1:0]              r_idx, n_idx;
    logic [kdas_pkg::LevelW-1:0]            r_levels, n_levels;
    logic [kdas_pkg::NumButtons-1:0]        r_on_mask, n_on_mask;
    logic                                   r_out_valid, n_out_valid;
    logic                                   r_event_valid, n_event_valid;
    kdas_pkg::t_kind                        r_event_kind, n_event_kind;
    logic [kdas_pkg::BtnW-1:0]              r_button_index, n_button_index;
    logic [kdas_pkg::BtnW-1:0]              r_other_button, n_other_button;

    logic [kdas_pkg::LimW-1:0]              r_debounce_limit;
    logic [kdas_pkg::LimW-1:0]              r_long_press_limit;
    logic [kdas_pkg::LimW-1:0]              r_rpt_interval;
    kdas_pkg::t_limits                      w_limits;

    logic                                   w_in_accept;
    logic                                   w_out_free;
    logic                                   w_pressed;
    logic                                   w_finish;
    logic                                   w_advance;
    logic                                   w_rd_en;
    logic [kdas_pkg::IdxW-1:0]              w_rd_addr;
    logic [kdas_pkg::IdxW-1:0]              w_idx_inc;
    kdas_pkg::t_btn_state                   w_cur;
    kdas_pkg::t_btn_state                   w_next;
    kdas_pkg::t_evt                         w_evt;
    logic [kdas_pkg::NumButtons-1:0]        w_mask_upd;
    logic                                   w_other_hit;
    logic [kdas_pkg::IdxW-1:0]              w_other;

    // Configuration registers
    assign o_cfg_ready = 1'b1;

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_debounce_limit   <= kdas_pkg::DebounceReset;
            r_long_press_limit <= kdas_pkg::LongPressReset;
            r_rpt_interval     <= kdas_pkg::RptReset;
        end else if (i_cfg_valid && o_cfg_ready) begin
            case (i_cfg_index)
                kdas_pkg::CFG_DEBOUNCE:   r_debounce_limit   <= i_cfg_data;
                kdas_pkg::CFG_LONG_PRESS: r_long_press_limit <= i_cfg_data;
                kdas_pkg::CFG_RPT:        r_rpt_interval     <= i_cfg_data;
                default: ;
            endcase
        end
    end

    assign w_limits.debounce     = r_debounce_limit;
    assign w_limits.long_press   = r_long_press_limit;
    assign w_limits.rpt_interval = r_rpt_interval;

    // Handshakes
    assign o_in_stall  = (r_state != ST_IDLE);
    assign w_in_accept = i_in_valid && !o_in_stall;
    assign w_out_free  = !r_out_valid || !i_out_stall;

    // Level of the button under scan; buttons past the pins read released
    assign w_pressed = (32'(r_idx) < kdas_pkg::LevelW) ?
                       !r_levels[3'(r_idx)] : 1'b0;

    kdas_btn_update u_btn_update (
        .i_cur     (w_cur),
        .i_pressed (w_pressed),
        .i_limits  (w_limits),
        .o_next    (w_next),
        .o_evt     (w_evt)
    );

    // Refresh the on-mode mask for this button and find the lowest other one
    always_comb begin
        w_mask_upd        = r_on_mask;
        w_mask_upd[r_idx] = (w_next.mode == kdas_pkg::MODE_ON);
        w_other_hit       = 1'b0;
        w_other           = '0;
        for (int j = kdas_pkg::NumButtons - 1; j >= 0; j--) begin
            if ((kdas_pkg::IdxW'(j) != r_idx) && w_mask_upd[j]) begin
                w_other_hit = 1'b1;
                w_other     = kdas_pkg::IdxW'(j);
            end
        end
    end

    // Write back the current button while reading the next one
    assign w_idx_inc = kdas_pkg::IdxW'(r_idx + 1'b1);
    assign w_finish  = (w_evt != kdas_pkg::EV_NONE) || (r_idx == IdxLast);
    assign w_advance = (r_state == ST_SCAN) && (!w_finish || w_out_free);
    assign w_rd_en   = w_in_accept || (w_advance && !w_finish);
    assign w_rd_addr = w_in_accept ? '0 : w_idx_inc;

    kdas_state_mem u_state_mem (
        .i_clk     (i_clk),
        .i_rst_n   (i_rst_n),
        .i_rd_en   (w_rd_en),
        .i_rd_addr (w_rd_addr),
        .o_rd_data (w_cur),
        .i_wr_en   (w_advance),
        .i_wr_addr (r_idx),
        .i_wr_data (w_next)
    );

    // Sequencer and result register next values
    always_comb begin
        n_state        = r_state;
        n_idx          = r_idx;
        n_levels       = r_levels;
        n_on_mask      = r_on_mask;
        n_out_valid    = r_out_valid;
        n_event_valid  = r_event_valid;
        n_event_kind   = r_event_kind;
        n_button_index = r_button_index;
        n_other_button = r_other_button;

        if (r_out_valid && !i_out_stall) begin
            n_out_valid = 1'b0;
        end

        case (r_state)
            ST_IDLE: begin
                if (w_in_accept) begin
                    n_levels = i_raw_levels;
                    n_idx    = '0;
                    n_state  = ST_SCAN;
                end
            end
            ST_SCAN: begin
                if (w_advance) begin
                    n_on_mask = w_mask_upd;
                    if (w_finish) begin
                        n_state     = ST_IDLE;
                        n_out_valid = 1'b1;
                        if (w_evt != kdas_pkg::EV_NONE) begin
                            n_event_valid  = 1'b1;
                            n_button_index = kdas_pkg::BtnW'(r_idx);
                            if (w_other_hit) begin
                                n_event_kind   = kdas_pkg::KIND_TWO;
                                n_other_button = kdas_pkg::BtnW'(w_other);
                            end else begin
                                n_event_kind   = (w_evt == kdas_pkg::EV_ON) ?
                                                 kdas_pkg::KIND_ON : kdas_pkg::KIND_REPEAT;
                                n_other_button = '0;
                            end
                        end else begin
                            n_event_valid  = 1'b0;
                            n_event_kind   = kdas_pkg::KIND_ON;
                            n_button_index = '0;
                            n_other_button = '0;
                        end
                    end else begin
                        n_idx = w_idx_inc;
                    end
                end
            end
            default: begin
                n_state = ST_IDLE;
            end
        endcase
    end

    // Hold state and registered outputs
    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_state        <= ST_IDLE;
            r_idx          <= '0;
            r_on_mask      <= '0;
            r_out_valid    <= 1'b0;
            r_levels       <= '0;
            r_event_valid  <= 1'b0;
            r_event_kind   <= kdas_pkg::KIND_ON;
            r_button_index <= '0;
            r_other_button <= '0;
        end else begin
            r_state        <= n_state;
            r_idx          <= n_idx;
            r_on_mask      <= n_on_mask;
            r_out_valid    <= n_out_valid;
            r_levels       <= n_levels;
            r_event_valid  <= n_event_valid;
            r_event_kind   <= n_event_kind;
            r_button_index <= n_button_index;
            r_other_button <= n_other_button;
        end
    end

    assign o_out_valid    = r_out_valid;
    assign o_event_valid  = r_event_valid;
    assign o_event_kind   = r_event_kind;
    assign o_button_index = r_button_index;
    assign o_other_button = r_other_button;

`ifndef SYNTH
    // An accepted item always starts a scan
    a_accept_starts_scan: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        w_in_accept |=> (r_state == ST_SCAN) && (r_idx == '0))
        else $error("accepted item did not start a scan");

    // Write-back and look-ahead read never hit the same entry
    a_no_rw_overlap: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        (w_advance && w_rd_en) |-> (w_rd_addr != r_idx))
        else $error("state memory read and write collide");

    // Scan index stays within the button range
    a_idx_range: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        (r_state == ST_SCAN) |-> (32'(r_idx) < kdas_pkg::NumButtons))
        else $error("scan index out of range");

    // A result without an event carries all-zero fields
    a_no_event_zero: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        (o_out_valid && !o_event_valid) |->
            ((o_event_kind == kdas_pkg::KIND_ON) && (o_button_index == '0) &&
             (o_other_button == '0)))
        else $error("empty result carries non-zero fields");

    // A new result is loaded only once the previous one has been taken
    a_no_overwrite: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        (r_out_valid && i_out_stall) |=> r_out_valid)
        else $error("pending result dropped");
`endif

endmodule

`default_nettype wire
